@@ rtl/vwbp_pkg.sv @@
`timescale 1ns / 1ps
package vwbp_pkg;

   // queue depths
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   // widest field, in bits
   localparam int MAX_WIDTH = 32;
   // longest bit string one word can append (continuation bits plus value)
   localparam int STREAM_W = 64;
   // width groups the group search tries per cycle
   localparam int STEPS_PER_CYCLE = 8;

   typedef enum logic [2:0] {
      OP_FIX_U = 3'd0,
      OP_FIX_S = 3'd1,
      OP_DYN_U = 3'd2,
      OP_DYN_S = 3'd3,
      OP_FLUSH = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_ERROR = 2'd1,
      KIND_FLUSH = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] data_value;
      logic [5:0]  field_width;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       error;
      logic       last;
   } rsp_word_type;

   // front to back: left-aligned bit string and its length
   typedef struct packed {
      cmd_kind_type        kind;
      logic [STREAM_W-1:0] stream;
      logic [5:0]          length;
   } cmd_word_type;

   // position of the highest set bit plus one, 0 for zero
   function automatic logic [5:0] bit_length(input logic [MAX_WIDTH-1:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         if (v[i]) n = 6'(i + 1);
      end
      return n;
   endfunction

endpackage

@@ rtl/vwbp_fifo.sv @@
`timescale 1ns / 1ps
module vwbp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = vwbp_pkg::CMD_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

@@ rtl/vwbp_front.sv @@
`timescale 1ns / 1ps
module vwbp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  vwbp_pkg::req_word_type req_data,
   output logic                   req_full,
   output logic                   cmd_push,
   output vwbp_pkg::cmd_word_type cmd_word,
   input  logic                   cmd_full
);

   localparam int SW = vwbp_pkg::STREAM_W;
   localparam int VW = vwbp_pkg::MAX_WIDTH;

   // stage 1: classified word
   logic                   s1_valid_ff, s1_valid_in;
   vwbp_pkg::cmd_kind_type s1_kind_ff, s1_kind_in;
   logic                   s1_dyn_ff, s1_dyn_in;
   logic [VW-1:0]          s1_value_ff;
   logic [5:0]             s1_width_ff;
   logic [5:0]             s1_need_ff, s1_need_in;

   // stage 2: group search and bit string build
   logic                   s2_valid_ff, s2_valid_in;
   vwbp_pkg::cmd_kind_type s2_kind_ff;
   logic                   s2_dyn_ff;
   logic [VW-1:0]          s2_value_ff;
   logic [5:0]             s2_width_ff;
   logic [5:0]             s2_need_ff;
   logic [6:0]             s2_shift_ff, s2_shift_in;
   logic [4:0]             s2_groups_ff, s2_groups_in;

   vwbp_pkg::opcode_type op_code;
   logic [5:0]  ubits, sbits, rbits;
   logic        is_signed, width_ok;
   logic        s1_load, s2_load, s2_take, s2_done;
   logic [5:0]  value_bits;
   logic        stop_bit;
   logic [SW-1:0] ones_mask, value_aligned, value_placed;

   // handshake between stages
   assign s2_done  = !s2_dyn_ff || (s2_shift_ff >= {1'b0, s2_need_ff})
                     || (s2_shift_ff >= 7'(VW));
   assign s2_take  = s2_valid_ff && s2_done && !cmd_full;
   assign s2_load  = s1_valid_ff && (!s2_valid_ff || s2_take);
   assign req_full = s1_valid_ff && !s2_load;
   assign s1_load  = req_push && !req_full;
   assign cmd_push = s2_take;

   // classify the incoming word
   always_comb begin
      op_code   = vwbp_pkg::opcode_type'(req_data.opcode);
      ubits     = vwbp_pkg::bit_length(req_data.data_value);
      sbits     = vwbp_pkg::bit_length(req_data.data_value
                                       ^ {VW{req_data.data_value[VW-1]}}) + 6'd1;
      is_signed = (op_code == vwbp_pkg::OP_FIX_S) || (op_code == vwbp_pkg::OP_DYN_S);
      rbits     = is_signed ? sbits : ubits;
      width_ok  = (req_data.field_width != '0) && (req_data.field_width <= 6'(VW));
      s1_dyn_in = 1'b0;
      unique case (op_code) inside
         vwbp_pkg::OP_FLUSH: s1_kind_in = vwbp_pkg::KIND_FLUSH;
         vwbp_pkg::OP_FIX_U, vwbp_pkg::OP_FIX_S: begin
            if (!width_ok || ((req_data.field_width < 6'(VW)) && (rbits > req_data.field_width)))
               s1_kind_in = vwbp_pkg::KIND_ERROR;
            else
               s1_kind_in = vwbp_pkg::KIND_WRITE;
         end
         vwbp_pkg::OP_DYN_U, vwbp_pkg::OP_DYN_S: begin
            s1_kind_in = width_ok ? vwbp_pkg::KIND_WRITE : vwbp_pkg::KIND_ERROR;
            s1_dyn_in  = width_ok;
         end
         default: s1_kind_in = vwbp_pkg::KIND_ERROR;
      endcase
      // a zero value still needs one bit
      s1_need_in  = (rbits == '0) ? 6'd1 : rbits;
      s1_valid_in = s1_load || (s1_valid_ff && !s2_load);
   end

   // grow the width, up to eight groups a cycle
   always_comb begin
      s2_shift_in  = s2_shift_ff;
      s2_groups_in = s2_groups_ff;
      if (s2_load) begin
         s2_shift_in  = {1'b0, s1_width_ff};
         s2_groups_in = '0;
      end else if (s2_valid_ff && !s2_done) begin
         for (int i = 0; i < vwbp_pkg::STEPS_PER_CYCLE; i++) begin
            if (!((s2_shift_in >= {1'b0, s2_need_ff}) || (s2_shift_in >= 7'(VW)))) begin
               s2_shift_in  = s2_shift_in + {1'b0, s2_width_ff};
               s2_groups_in = s2_groups_in + 1'b1;
            end
         end
      end
      s2_valid_in = s2_load || (s2_valid_ff && !s2_take);
   end

   // continuation ones, stop bit, then the value, left-aligned
   always_comb begin
      if (s2_dyn_ff)
         value_bits = (s2_shift_ff >= 7'(VW)) ? 6'(VW) : s2_shift_ff[5:0];
      else
         value_bits = s2_width_ff;
      stop_bit      = s2_dyn_ff && (s2_shift_ff < 7'(VW));
      ones_mask     = ~({SW{1'b1}} >> s2_groups_ff);
      value_aligned = {s2_value_ff, {(SW - VW){1'b0}}} << (6'(VW) - value_bits);
      value_placed  = value_aligned >> (6'(s2_groups_ff) + 6'(stop_bit));
      cmd_word.kind   = s2_kind_ff;
      cmd_word.stream = ones_mask | value_placed;
      cmd_word.length = 6'(s2_groups_ff) + 6'(stop_bit) + value_bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_kind_ff  <= s1_kind_in;
         s1_dyn_ff   <= s1_dyn_in;
         s1_value_ff <= req_data.data_value;
         s1_width_ff <= req_data.field_width;
         s1_need_ff  <= s1_need_in;
      end
      if (s2_load) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_dyn_ff   <= s1_dyn_ff;
         s2_value_ff <= s1_value_ff;
         s2_width_ff <= s1_width_ff;
         s2_need_ff  <= s1_need_ff;
      end
      s2_shift_ff  <= s2_shift_in;
      s2_groups_ff <= s2_groups_in;
   end

endmodule

@@ rtl/vwbp_back.sv @@
`timescale 1ns / 1ps
module vwbp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  vwbp_pkg::cmd_word_type cmd_word,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   output logic                   rsp_push,
   output vwbp_pkg::rsp_word_type rsp_word,
   input  logic                   rsp_full
);

   localparam int SW = vwbp_pkg::STREAM_W;

   logic [6:0] pend_bits_ff, pend_bits_in;
   logic [2:0] pend_count_ff, pend_count_in;
   logic [5:0] used_ff, used_in;

   logic [SW-1:0] window;
   logic [7:0]    top8, full_byte, part_byte, flush_byte;
   logic [3:0]    room;
   logic [5:0]    remain;
   logic          active;

   // next bits of the current string and how they merge with the partial byte
   always_comb begin
      window     = cmd_word.stream << used_ff;
      top8       = window[SW-1:SW-8];
      room       = 4'd8 - {1'b0, pend_count_ff};
      remain     = cmd_word.length - used_ff;
      full_byte  = ({1'b0, pend_bits_ff} << room) | (top8 >> pend_count_ff);
      part_byte  = ({1'b0, pend_bits_ff} << remain[2:0])
                   | (top8 >> (4'd8 - {1'b0, remain[2:0]}));
      flush_byte = {1'b0, pend_bits_ff} << room;
      active     = !cmd_empty && !rsp_full;
   end

   // one output byte per cycle at most
   always_comb begin
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp_word      = '0;
      pend_bits_in  = pend_bits_ff;
      pend_count_in = pend_count_ff;
      used_in       = used_ff;
      if (active) begin
         unique case (cmd_word.kind)
            vwbp_pkg::KIND_ERROR: begin
               cmd_pop        = 1'b1;
               rsp_push       = 1'b1;
               rsp_word.error = 1'b1;
               rsp_word.last  = 1'b1;
            end
            vwbp_pkg::KIND_FLUSH: begin
               cmd_pop = 1'b1;
               if (pend_count_ff != '0) begin
                  rsp_push            = 1'b1;
                  rsp_word.out_byte   = flush_byte;
                  rsp_word.byte_valid = 1'b1;
                  rsp_word.last       = 1'b1;
                  pend_bits_in        = '0;
                  pend_count_in       = '0;
               end
            end
            vwbp_pkg::KIND_WRITE: begin
               if ({2'b0, room} <= remain) begin
                  // byte completes; last when fewer than eight bits stay behind
                  rsp_push            = 1'b1;
                  rsp_word.out_byte   = full_byte;
                  rsp_word.byte_valid = 1'b1;
                  rsp_word.last       = (remain - {2'b0, room}) < 6'd8;
                  pend_bits_in        = '0;
                  pend_count_in       = '0;
                  if (remain == {2'b0, room}) begin
                     cmd_pop = 1'b1;
                     used_in = '0;
                  end else begin
                     used_in = used_ff + {2'b0, room};
                  end
               end else begin
                  // tail goes into the partial byte
                  cmd_pop       = 1'b1;
                  pend_bits_in  = part_byte[6:0];
                  pend_count_in = pend_count_ff + remain[2:0];
                  used_in       = '0;
               end
            end
            default: cmd_pop = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
         used_ff       <= '0;
      end else begin
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
         used_ff       <= used_in;
      end
   end

endmodule

@@ rtl/variable_width_bit_packer.sv @@
`timescale 1ns / 1ps
// MSB-first bit packer. Each input word appends a fixed or self-extending
// field to a byte stream, or flushes the partial byte zero-padded; rejected
// words give one error result and leave the stream untouched. The front end
// takes one word per clock unless held: it classifies the word, then
// searches the width groups of a dynamic field eight per cycle, so a dynamic
// field with a small group size holds it while the search runs, as does a
// full command queue. The back end drains one completed byte per clock while
// a command waits and the result queue has room: a write emits each byte it
// completes, then moves any leftover bits into the partial byte; a flush gives
// at most one result. A command queue between the two and a result queue at
// the output let either side stall alone. An accepted word passes stage 1,
// stage 2 and the command queue before its first result is queued.
module variable_width_bit_packer #(
   parameter int CMD_DEPTH = vwbp_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH = vwbp_pkg::RSP_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  vwbp_pkg::req_word_type req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output vwbp_pkg::rsp_word_type rsp_data
);

   localparam int CMD_W = $bits(vwbp_pkg::cmd_word_type);
   localparam int RSP_W = $bits(vwbp_pkg::rsp_word_type);

   vwbp_pkg::cmd_word_type cmd_in_word, cmd_out_word;
   vwbp_pkg::rsp_word_type rsp_in_word;
   logic [CMD_W-1:0]       cmd_rd_bits;
   logic [RSP_W-1:0]       rsp_rd_bits;
   logic cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic rsp_push, rsp_full;

   vwbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_word (cmd_in_word),
      .cmd_full (cmd_full)
   );

   vwbp_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_in_word),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_bits),
      .empty   (cmd_empty)
   );

   assign cmd_out_word = vwbp_pkg::cmd_word_type'(cmd_rd_bits);

   vwbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_word  (cmd_out_word),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_in_word),
      .rsp_full  (rsp_full)
   );

   vwbp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_in_word),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd_bits),
      .empty   (rsp_empty)
   );

   assign rsp_data = vwbp_pkg::rsp_word_type'(rsp_rd_bits);

endmodule
